/* hw/rtl/crw_pkg.sv */
// shared constants and types for the carriage-return framed 7-bit word decoder
package crw_pkg;

	// byte codes
	localparam logic [7:0] CrByte   = 8'h0D;
	localparam logic [7:0] NullByte = 8'h00;

	// packing of 7-bit groups into the command word
	localparam int GroupBits    = 7;
	localparam int WordBits     = 32;
	localparam int GroupsInWord = (WordBits + GroupBits - 1) / GroupBits;

	// payload widths
	localparam int ByteW   = 8;
	localparam int CountW  = 8;
	localparam int FrameLenW = 3;
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	// configuration port
	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;
	localparam logic [FrameLenW-1:0] FrameLengthReset = 3'd5;

	// register index, taken from the word address bit
	localparam logic RegFrameLength = 1'b0;

	// result status codes
	typedef enum logic {
		STATUS_OK         = 1'b0,
		STATUS_LENGTH_ERR = 1'b1
	} status_t;

	typedef logic [ByteW-1:0]    byte_t;
	typedef logic [WordBits-1:0] word_t;
	typedef logic [CountW-1:0]   count_t;

endpackage

/* hw/rtl/crw_if.sv */
// valid/ready channel interfaces for received bytes and decoded results
interface crw_in_if;
	logic           valid;
	logic           ready;
	crw_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crw_out_if;
	logic             valid;
	logic             ready;
	crw_pkg::status_t status;
	crw_pkg::word_t   command_word;
	crw_pkg::count_t  received_length;

	modport source (output valid, output status, output command_word,
		output received_length, input ready);
	modport sink   (input valid, input status, input command_word,
		input received_length, output ready);
endinterface

/* hw/rtl/cr_framed_7bit_word_decoder_unit.sv */
// top level of the carriage-return framed 7-bit word decoder
//
// channel  | direction | payload
// ---------+-----------+-------------------------------------------------
// rx       | in        | rx_byte[7:0]
// result   | out       | status, command_word[31:0], received_length[7:0]
// apb      | in        | frame_length at byte address 0, bits [2:0]
//
// one byte per cycle unless a carriage return waits on a stalled result; a
// carriage return's result passes the input register, then the result register.
// arst_n clears the frame state, both valid flags and frame_length (to 5).
// a result stalled on result.ready only stops rx when the byte in the input
// register is itself a carriage return; other bytes keep flowing.
module cr_framed_7bit_word_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	crw_in_if.sink                        rx,
	crw_out_if.source                     result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crw_pkg::ApbAddrW-1:0]  paddr,
	input  logic [crw_pkg::ApbDataW-1:0]  pwdata,
	output logic [crw_pkg::ApbDataW-1:0]  prdata,
	output logic                          pready
);

	logic [crw_pkg::FrameLenW-1:0]     frame_len_q;
	logic                              valid_s1;
	crw_pkg::byte_t                    byte_s1;
	crw_pkg::word_t                    partial_q;
	crw_pkg::count_t                   count_q;
	logic                              out_valid_q;
	crw_pkg::status_t                  status_q;
	crw_pkg::word_t                    word_q;
	crw_pkg::count_t                   length_q;
	logic                              is_cr_s1;
	logic                              is_null_s1;
	logic                              adv_s1;
	logic                              out_free;
	logic                              cfg_wr;
	logic [4:0]                        offset;
	crw_pkg::word_t                    group_word;
	logic                              len_ok;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == crw_pkg::RegFrameLength);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= crw_pkg::FrameLengthReset;
		end else if (cfg_wr) begin
			frame_len_q <= pwdata[crw_pkg::FrameLenW-1:0];
		end
	end

	// register read back
	always_comb begin
		prdata = '0;
		if (paddr[2] == crw_pkg::RegFrameLength) begin
			prdata[crw_pkg::FrameLenW-1:0] = frame_len_q;
		end
	end

	// stage 1 control: a carriage return needs a free result slot
	assign is_cr_s1   = (byte_s1 == crw_pkg::CrByte);
	assign is_null_s1 = (byte_s1 == crw_pkg::NullByte);
	assign out_free   = !out_valid_q || result.ready;
	assign adv_s1     = valid_s1 && (!is_cr_s1 || out_free);
	assign rx.ready   = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// group placement: offsets 0, 7, 14, 21, 28 for the first five bytes
	always_comb begin
		offset     = {2'b00, count_q[2:0]} * 5'd7;
		group_word = crw_pkg::word_t'(byte_s1[crw_pkg::GroupBits-1:0]) << offset;
		if (count_q >= crw_pkg::count_t'(crw_pkg::GroupsInWord)) begin
			group_word = '0;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			count_q   <= '0;
		end else if (adv_s1 && !is_null_s1) begin
			if (is_cr_s1) begin
				partial_q <= '0;
				count_q   <= '0;
			end else begin
				partial_q <= partial_q | group_word;
				if (count_q != crw_pkg::CountMax) begin
					count_q <= count_q + 8'd1;
				end
			end
		end
	end

	// result register
	assign len_ok = (count_q == crw_pkg::count_t'(frame_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && is_cr_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_cr_s1) begin
			status_q <= len_ok ? crw_pkg::STATUS_OK : crw_pkg::STATUS_LENGTH_ERR;
			word_q   <= len_ok ? partial_q : '0;
			length_q <= count_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.status          = status_q;
	assign result.command_word    = word_q;
	assign result.received_length = length_q;

`ifndef ASSERT_OFF
	// a carriage return always clears the frame state
	a_cr_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && is_cr_s1) |=> (count_q == '0 && partial_q == '0))
		else $error("frame state not cleared after carriage return");

	// a carriage return always produces a result
	a_cr_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && is_cr_s1) |=> result.valid)
		else $error("carriage return gave no result");

	// a null byte leaves the frame state alone
	a_null_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && is_null_s1) |=> ($stable(count_q) && $stable(partial_q)))
		else $error("null byte changed frame state");

	// an error result carries no command word
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == crw_pkg::STATUS_LENGTH_ERR)
		|-> (result.command_word == '0))
		else $error("length error with nonzero command word");
`endif

endmodule

/* bench/testbench.sv */
// self-checking bench for the carriage-return framed 7-bit word decoder
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import crw_pkg::*;

	localparam int ItemTarget    = 1700;
	localparam int SettleCycles  = 4;    // two-stage pipe plus margin
	localparam int HoldOffCycles = 200;
	localparam int StallLimit    = 2000;

	localparam logic [ApbAddrW-1:0] FrameLengthAddr = ApbAddrW'(0);
	localparam logic [ApbAddrW-1:0] SpareAddr       = ApbAddrW'(4);

	// frame_length values walked by the first random phases, extremes first
	localparam logic [8*FrameLenW-1:0] LengthSweep =
		{3'd4, 3'd3, 3'd5, 3'd2, 3'd6, 3'd1, 3'd7, 3'd0};

	typedef struct packed {
		status_t status;
		word_t   command_word;
		count_t  received_length;
	} frame_result_t;

	localparam frame_result_t NoResult = '{STATUS_OK, '0, '0};

	// per-byte note: an expected result typed in by hand, if any
	typedef struct packed {
		bit            given;
		frame_result_t res;
	} byte_note_t;

	typedef enum logic {
		ROW_BYTE,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [ApbAddrW-1:0]     addr;
		logic [ApbDataW-1:0]     data;
		bit                      given;
		frame_result_t           res;
	} directed_row_t;

	localparam int DirectedRows = 24;
	localparam directed_row_t Directed [DirectedRows] = '{
		// empty frame at the reset length
		'{ROW_BYTE,  FrameLengthAddr, CrByte,   1'b1, '{STATUS_LENGTH_ERR, 32'h0, 8'd0}},
		'{ROW_BYTE,  FrameLengthAddr, NullByte, 1'b0, NoResult},
		// five payload bytes with a zero byte mixed in, high bits dropped
		'{ROW_BYTE,  FrameLengthAddr, 8'h7F,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, 8'h80,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, 8'h8D,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, 8'h01,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, 8'h55,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, NullByte, 1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, CrByte,   1'b0, NoResult},
		// frame one byte too long
		'{ROW_BYTE,  FrameLengthAddr, 8'hFF,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, 8'hFF,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, 8'hFF,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, 8'hFF,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, 8'hFF,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, 8'hFF,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, CrByte,   1'b1, '{STATUS_LENGTH_ERR, 32'h0, 8'd6}},
		// shortest nonzero length
		'{ROW_WRITE, FrameLengthAddr, 32'd1,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, CrByte,   1'b1, '{STATUS_LENGTH_ERR, 32'h0, 8'd0}},
		'{ROW_BYTE,  FrameLengthAddr, 8'hAB,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, CrByte,   1'b1, '{STATUS_OK, 32'h2B, 8'd1}},
		// length zero makes the empty frame valid
		'{ROW_WRITE, FrameLengthAddr, 32'd0,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, CrByte,   1'b1, '{STATUS_OK, 32'h0, 8'd0}},
		// write past the last register leaves frame_length alone
		'{ROW_WRITE, SpareAddr,       32'd7,    1'b0, NoResult},
		'{ROW_BYTE,  FrameLengthAddr, CrByte,   1'b1, '{STATUS_OK, 32'h0, 8'd0}}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	crw_in_if  rx_ch ();
	crw_out_if res_ch ();

	cr_framed_7bit_word_decoder_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder state as the bench sees it
	logic [FrameLenW-1:0] frame_len;
	word_t                packed_word;
	count_t               payload_count;

	frame_result_t frame_results_due [$];
	byte_note_t    byte_notes [$];
	int            mismatches   = 0;
	int            sent_payload = 0;
	int            quiet_cycles = 0;
	bit            steady       = 1'b0;
	bit            hold_req     = 1'b0;

	// fold one received byte into the frame; returns 1 when a frame closes
	function automatic bit decode_byte(input byte_t b, output frame_result_t r);
		int unsigned offset;
		bit          length_ok;
		r = NoResult;
		if (b == NullByte)
			return 1'b0;
		if (b == CrByte) begin
			length_ok = (payload_count == count_t'(frame_len));
			r.status          = length_ok ? STATUS_OK : STATUS_LENGTH_ERR;
			r.command_word    = length_ok ? packed_word : '0;
			r.received_length = payload_count;
			packed_word   = '0;
			payload_count = '0;
			return 1'b1;
		end
		offset = GroupBits * payload_count;
		if (offset < WordBits)
			packed_word |= word_t'(b[GroupBits-1:0]) << offset;
		if (payload_count != CountMax)
			payload_count++;
		return 1'b0;
	endfunction

	// track byte and result transactions, check results, count quiet cycles
	always @(posedge clk) begin : track
		byte_note_t    note;
		frame_result_t predicted;
		frame_result_t want;
		bit            active;
		active = 1'b0;
		if (rx_ch.valid && rx_ch.ready) begin
			active = 1'b1;
			note = byte_notes.pop_front();
			if (decode_byte(rx_ch.rx_byte, predicted))
				frame_results_due.push_back(note.given ? note.res : predicted);
		end
		if (res_ch.valid && res_ch.ready) begin
			active = 1'b1;
			if (frame_results_due.size() == 0) begin
				$error("result transaction with no expected frame result waiting");
				mismatches++;
			end else begin
				want = frame_results_due.pop_front();
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_ch.status);
					mismatches++;
				end
				if (res_ch.command_word !== want.command_word) begin
					$error("command_word: expected %08h, got %08h",
						want.command_word, res_ch.command_word);
					mismatches++;
				end
				if (res_ch.received_length !== want.received_length) begin
					$error("received_length: expected %0d, got %0d",
						want.received_length, res_ch.received_length);
					mismatches++;
				end
			end
		end
		if (psel && penable && pwrite && pready)
			active = 1'b1;
		quiet_cycles <= active ? 0 : quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= StallLimit);
		$display("testbench NOT OK");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
			end else begin
				res_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// offer one byte and wait for its transaction; valid stays high afterwards
	task automatic send_byte(input byte_t b, input bit given = 1'b0,
			input frame_result_t res = NoResult);
		int gap;
		byte_notes.push_back('{given, res});
		if (!steady && $urandom_range(0, 99) < 25) begin
			gap = 1;
			while ($urandom_range(0, 99) < 25)
				gap++;
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= byte_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_ch.ready);
		if (b != NullByte)
			sent_payload++;
	endtask

	// payload bytes with stray zero bytes, optionally closed by a carriage return
	task automatic send_frame(input int n, input bit close);
		byte_t b;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_byte(NullByte);
			do
				b = byte_t'($urandom_range(1, 255));
			while (b == CrByte);
			send_byte(b);
		end
		if (close)
			send_byte(CrByte);
	endtask

	// stop sending and let every pending result come out
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (frame_results_due.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// register write, then read back frame_length
	task automatic reg_write(input logic [ApbAddrW-1:0] addr,
			input logic [ApbDataW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr[ApbAddrW-1:2] == RegFrameLength)
			frame_len = data[FrameLenW-1:0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= FrameLengthAddr;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[FrameLenW-1:0] !== frame_len) begin
			$error("frame_length: expected %0d, got %0d", frame_len,
				prdata[FrameLenW-1:0]);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int          phase;
		int          frames;
		int          pick;
		logic [ApbDataW-1:0] setting;

		arst_n        <= 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		frame_len     = FrameLengthReset;
		packed_word   = '0;
		payload_count = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DirectedRows; i++) begin
			if (Directed[i].kind == ROW_WRITE) begin
				drain();
				reg_write(Directed[i].addr, Directed[i].data);
			end else begin
				send_byte(Directed[i].data[ByteW-1:0], Directed[i].given,
					Directed[i].res);
			end
		end

		// random phases, each under its own frame_length
		phase = 0;
		while (sent_payload < ItemTarget) begin
			drain();
			setting = phase < 8 ? ApbDataW'(LengthSweep[FrameLenW*phase +: FrameLenW])
				: ApbDataW'($urandom_range(0, 7));
			if (phase % 5 == 4)
				reg_write(SpareAddr, $urandom);
			reg_write(FrameLengthAddr, ($urandom & ~ApbDataW'(7)) | setting);
			steady = (phase == 3 || phase == 4);
			// receiver holds off while short frames keep coming
			if (phase == 3)
				hold_req = 1'b1;
			frames = phase == 3 ? 40 : $urandom_range(8, 25);
			for (int f = 0; f < frames; f++) begin
				pick = $urandom_range(0, 199);
				if ((phase == 1 && f == 0) || pick == 0) begin
					// count saturation
					send_frame($urandom_range(256, 300), 1'b1);
				end else if (pick < 130) begin
					send_frame(frame_len, 1'b1);
				end else if (pick < 170) begin
					send_frame($urandom_range(0, 8), 1'b1);
				end else if (pick < 190) begin
					// noise, frequent carriage returns
					repeat ($urandom_range(1, 12))
						send_byte($urandom_range(0, 9) == 0 ? CrByte
							: byte_t'($urandom));
				end else begin
					send_frame($urandom_range(9, 20), 1'b1);
				end
			end
			// leave a frame open across the next register write
			if ($urandom_range(0, 1) == 1)
				send_frame($urandom_range(1, 4), 1'b0);
			phase++;
		end
		steady = 1'b0;
		drain();

		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/crw_pkg.sv
hw/rtl/crw_if.sv
hw/rtl/cr_framed_7bit_word_decoder_unit.sv
bench/testbench.sv
